### hdl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 72;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic load;
        logic exec;
        logic read;
    } dq_cmd_t;

endpackage

### hdl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: capture request, apply operation, read ends, present result.
// ----------------------------------------------------------------------------
module dq_ctrl
    import dq_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dq_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_RESP
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;
    logic   exec_reg;
    logic   read_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
            exec_reg     <= 1'b0;
            read_reg     <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg    <= ST_EXEC;
                        s_tready_reg <= 1'b0;
                        exec_reg     <= 1'b1;
                    end
                end
                ST_EXEC: begin
                    state_reg <= ST_READ;
                    exec_reg  <= 1'b0;
                    read_reg  <= 1'b1;
                end
                ST_READ: begin
                    state_reg    <= ST_RESP;
                    read_reg     <= 1'b0;
                    m_tvalid_reg <= 1'b1;
                end
                ST_RESP: begin
                    if (m_tready) begin
                        state_reg    <= ST_IDLE;
                        m_tvalid_reg <= 1'b0;
                        s_tready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg    <= ST_IDLE;
                    s_tready_reg <= 1'b1;
                    m_tvalid_reg <= 1'b0;
                    exec_reg     <= 1'b0;
                    read_reg     <= 1'b0;
                end
            endcase
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;
    assign cmd.load = s_tvalid & s_tready_reg;
    assign cmd.exec = exec_reg;
    assign cmd.read = read_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready_reg && m_tvalid_reg))
        else $error("request and result sides open together");

    a_load_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (exec_reg && !s_tready_reg))
        else $error("accepted request not executed");

    a_read_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        read_reg |=> (m_tvalid_reg && !read_reg && !exec_reg))
        else $error("read not followed by result");

endmodule

### hdl/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath
// Ring buffer storage, front index and count, result formatting.
// ----------------------------------------------------------------------------
module dq_datapath
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dq_cmd_t              cmd,
    input  logic [S_TDATA_W-1:0] in_data,
    output logic [M_TDATA_W-1:0] out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] val_reg;
    logic [AW-1:0]     front_reg;
    logic [AW-1:0]     front_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] front_rd_reg;
    logic [DATA_W-1:0] back_rd_reg;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW:0]       tail_sum;
    logic [AW-1:0]     tail_addr;
    logic [AW:0]       back_sum;
    logic [AW-1:0]     back_addr;
    logic [AW-1:0]     front_dec;
    logic [AW-1:0]     front_inc;
    logic              is_empty;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_data[OP_W-1:0];
            val_reg <= in_data[OP_W+DATA_W-1:OP_W];
        end
    end

    // ring arithmetic, one wrap correction each
    always_comb begin
        tail_sum  = {1'b0, front_reg} + (AW + 1)'(count_reg);
        tail_addr = (tail_sum >= DEPTH_A) ? AW'(tail_sum - DEPTH_A) : AW'(tail_sum);
        back_sum  = tail_sum - (AW + 1)'(1);
        back_addr = (back_sum >= DEPTH_A) ? AW'(back_sum - DEPTH_A) : AW'(back_sum);
        front_dec = (front_reg == '0) ? LAST_A : front_reg - AW'(1);
        front_inc = (front_reg == LAST_A) ? '0 : front_reg + AW'(1);
    end

    always_comb begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        wr_en       = 1'b0;
        wr_addr     = tail_addr;
        case (op_reg)
            OP_PUSH_BACK: begin
                if (count_reg == FULL_C) begin
                    status_next = ST_OVERFLOW;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_PUSH_FRONT: begin
                if (count_reg == FULL_C) begin
                    status_next = ST_OVERFLOW;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = front_dec;
                    front_next = front_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_POP_FRONT: begin
                if (count_reg == '0) begin
                    status_next = ST_UNDERFLOW;
                end else begin
                    front_next = front_inc;
                    count_next = count_reg - CW'(1);
                end
            end
            OP_POP_BACK: begin
                if (count_reg == '0) begin
                    status_next = ST_UNDERFLOW;
                end else begin
                    count_next = count_reg - CW'(1);
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg  <= '0;
            count_reg  <= '0;
            status_reg <= ST_OK;
        end else if (cmd.exec) begin
            front_reg  <= front_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_en) begin
            mem[wr_addr] <= val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            front_rd_reg <= mem[front_reg];
            back_rd_reg  <= mem[back_addr];
        end
    end

    assign is_empty = (count_reg == '0);

    assign out_data = {status_reg,
                       is_empty,
                       COUNT_W'(count_reg),
                       is_empty ? EMPTY_VALUE : back_rd_reg,
                       is_empty ? EMPTY_VALUE : front_rd_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_C)
        else $error("count beyond depth");

    a_front_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        front_reg <= LAST_A)
        else $error("front index out of ring");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.exec |=> ($stable(count_reg) && $stable(front_reg)))
        else $error("state changed without an operation");

endmodule

### hdl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Deque of signed 32-bit values in a ring buffer of DEPTH entries.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request: operation (push back, push front,
//   pop front, pop back, query) and a value for pushes.
//   m_ channel returns one result per request: front and back values
//   (-1 when empty), count, empty flag and status (ok, underflow, overflow).
//   A request is handled in sequencer steps: capture, update of store and
//   indexes, registered read of both ends of the ring, then result with
//   m_tvalid high. One request is handled at a time; the next is accepted
//   the cycle after the result is taken.
//   Reset empties the deque (front index and count cleared), s_tready
//   comes up high. Stored entries are not cleared.
//   When the receiver stalls, the result holds and no request is taken.
// ----------------------------------------------------------------------------
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // operation[2:0], value[34:3], zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // front_value, back_value, count,
                                           // is_empty, status
);

    dq_cmd_t cmd;

    dq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .out_data (m_tdata)
    );

endmodule

### verif/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the ring-buffer deque. A short directed table
// covers empty, full, underflow, overflow and unused opcodes. Random blocks
// biased toward filling, draining or mixed traffic follow. Every result is
// compared per field against the table or an in-bench deque tracker. Both
// channels idle at random; the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
    import dq_pkg::*;

    localparam int DEPTH         = 16;
    localparam int IDX_W         = $clog2(DEPTH);
    localparam int RANDOM_BLOCKS = 40;
    localparam int BLOCK_ITEMS   = 40;
    localparam int PRESSURE_AT   = 700;
    localparam int PRESSURE_HOLD = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;

    // packed high to low so that it overlays m_tdata directly
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic                     is_empty;
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] back_value;
        logic signed [DATA_W-1:0] front_value;
    } deque_result_t;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
        bit                typed;
        deque_result_t     result;
    } stim_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic signed [DATA_W-1:0] ring_model [DEPTH];
    logic [IDX_W-1:0]         head_idx   = '0;
    logic [COUNT_W-1:0]       held_count = '0;

    deque_result_t pending_results [$];
    stim_row_t     directed_rows [$];
    int            mismatch_count = 0;
    int            results_taken  = 0;
    int            idle_cycles    = 0;
    bit            sender_burst   = 1'b0;
    bit            receiver_burst = 1'b0;

    double_ended_queue #(.DEPTH(DEPTH)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("[%0t] timeout: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // applies one request to the tracked deque and returns the result it gives
    function automatic deque_result_t apply_operation(logic [OP_W-1:0] op,
                                                      logic signed [DATA_W-1:0] val);
        deque_result_t    r;
        logic [IDX_W-1:0] slot;
        r.status = ST_OK;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (held_count == DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    if (op == OP_PUSH_BACK) begin
                        slot = head_idx + held_count[IDX_W-1:0];
                        ring_model[slot] = val;
                    end else begin
                        head_idx = head_idx - 1'b1;
                        ring_model[head_idx] = val;
                    end
                    held_count = held_count + 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (held_count == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    if (op == OP_POP_FRONT) begin
                        head_idx = head_idx + 1'b1;
                    end
                    held_count = held_count - 1'b1;
                end
            end
            default: ;
        endcase
        r.count    = held_count;
        r.is_empty = (held_count == 0);
        if (held_count == 0) begin
            r.front_value = EMPTY_VALUE;
            r.back_value  = EMPTY_VALUE;
        end else begin
            slot = head_idx + held_count[IDX_W-1:0] - 1'b1;
            r.front_value = ring_model[head_idx];
            r.back_value  = ring_model[slot];
        end
        return r;
    endfunction

    function automatic void add_row(logic [OP_W-1:0] op, logic [DATA_W-1:0] value);
        stim_row_t row;
        row.op     = op;
        row.value  = value;
        row.typed  = 1'b0;
        row.result = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked_row(logic [OP_W-1:0] op, logic [DATA_W-1:0] value,
                                            logic [DATA_W-1:0] front, logic [DATA_W-1:0] back,
                                            int count, bit empty, logic [STATUS_W-1:0] status);
        stim_row_t row;
        row.op                 = op;
        row.value              = value;
        row.typed              = 1'b1;
        row.result.front_value = front;
        row.result.back_value  = back;
        row.result.count       = COUNT_W'(count);
        row.result.is_empty    = empty;
        row.result.status      = status;
        directed_rows.push_back(row);
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] val,
                                bit typed, deque_result_t typed_result);
        int            gap;
        deque_result_t predicted;
        gap = sender_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - OP_W - DATA_W){1'b0}}, val, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_operation(op, val);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic receive_results();
        int            gap;
        deque_result_t got;
        deque_result_t want;
        forever begin
            if (results_taken % 32 == 0) begin
                receiver_burst = ($urandom_range(0, 3) == 0);
            end
            gap = receiver_burst ? 0 : $urandom_range(0, 11);
            if (results_taken == PRESSURE_AT) begin
                gap = PRESSURE_HOLD;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got = deque_result_t'(m_tdata);
            results_taken++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", m_tdata[DATA_W-1:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (got.front_value !== want.front_value)
                    report_mismatch("front_value", got.front_value, want.front_value);
                if (got.back_value !== want.back_value)
                    report_mismatch("back_value", got.back_value, want.back_value);
                if (got.count !== want.count)
                    report_mismatch("count", DATA_W'(got.count), DATA_W'(want.count));
                if (got.is_empty !== want.is_empty)
                    report_mismatch("is_empty", DATA_W'(got.is_empty),
                                    DATA_W'(want.is_empty));
                if (got.status !== want.status)
                    report_mismatch("status", DATA_W'(got.status), DATA_W'(want.status));
            end
        end
    endtask

    initial begin
        int                       pick;
        int                       push_share;
        logic [OP_W-1:0]          op;
        logic [DATA_W-1:0]        val;
        for (int i = 0; i < DEPTH; i++) begin
            ring_model[i] = '0;
        end

        add_checked_row(OP_QUERY, '0, EMPTY_VALUE, EMPTY_VALUE, 0, 1'b1, ST_OK);
        add_checked_row(OP_POP_FRONT, '0, EMPTY_VALUE, EMPTY_VALUE, 0, 1'b1, ST_UNDERFLOW);
        add_checked_row(OP_POP_BACK, '1, EMPTY_VALUE, EMPTY_VALUE, 0, 1'b1, ST_UNDERFLOW);
        // highest unused opcode acts as a query
        add_checked_row('1, '1, EMPTY_VALUE, EMPTY_VALUE, 0, 1'b1, ST_OK);
        add_checked_row(OP_PUSH_BACK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        1, 1'b0, ST_OK);
        add_checked_row(OP_PUSH_FRONT, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                        2, 1'b0, ST_OK);
        add_row(OP_POP_BACK, '0);
        add_checked_row(OP_POP_FRONT, '0, EMPTY_VALUE, EMPTY_VALUE, 0, 1'b1, ST_OK);
        // fill to capacity from both ends, wrapping the head index
        for (int i = 0; i < DEPTH; i++) begin
            add_row(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, 32'hA5A5_0000 + i);
        end
        add_checked_row(OP_PUSH_BACK, '0, 32'hA5A5_000F, 32'hA5A5_000E,
                        DEPTH, 1'b0, ST_OVERFLOW);
        add_checked_row(OP_PUSH_FRONT, '1, 32'hA5A5_000F, 32'hA5A5_000E,
                        DEPTH, 1'b0, ST_OVERFLOW);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            receive_results();
        join_none

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].op, directed_rows[i].value,
                         directed_rows[i].typed, directed_rows[i].result);
        end

        // blocks lean toward filling, draining or mixed traffic
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            case ($urandom_range(0, 2))
                0:       push_share = 75;
                1:       push_share = 30;
                default: push_share = 53;
            endcase
            sender_burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < BLOCK_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    op = OP_W'($urandom_range(4, 7));
                end else if (pick < push_share) begin
                    op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                end else begin
                    op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
                end
                if ($urandom_range(0, 7) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       val = 32'h7FFF_FFFF;
                        1:       val = 32'h8000_0000;
                        2:       val = '0;
                        default: val = '1;
                    endcase
                end else begin
                    val = $urandom;
                end
                send_request(op, val, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
